@@ hw/rtl/printf_stream_formatter_top_macros.svh @@
// assertion macros for the printf stream formatter
`ifndef PRINTF_STREAM_FORMATTER_TOP_MACROS_SVH
`define PRINTF_STREAM_FORMATTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define PSF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define PSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PSF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define PSF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/psf_pkg.sv @@
// shared types, codes and tables of the printf stream formatter
package psf_pkg;

  localparam int MAX_WIDTH_DEF = 63;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int NDIG = 10;

  localparam logic [1:0] KIND_FMT = 2'd0;
  localparam logic [1:0] KIND_ARG = 2'd1;
  localparam logic [1:0] KIND_STR = 2'd2;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_SPEC = 2'd1,
    MODE_ARG  = 2'd2,
    MODE_STR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CT_CHAR = 2'd0,
    CT_SDEC = 2'd1,
    CT_UDEC = 2'd2,
    CT_HEX  = 2'd3
  } ctype_t;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_BAD,
    OP_ERRTXT,
    OP_PAD,
    OP_NUM
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_OUT,
    B_ERR
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  chr;
    logic [31:0] word;
    ctype_t      ctype;
    logic [5:0]  width;
    logic        zf;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    c = (d < 4'd10) ? (8'h30 + {4'b0, d}) : (8'h57 + {4'b0, d});
    return c;
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0: c = 8'h45;
      3'd1: c = 8'h52;
      3'd2: c = 8'h52;
      3'd3: c = 8'h4f;
      default: c = 8'h52;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/psf_if.sv @@
// stream channel interfaces for input items and output characters
interface psf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [31:0] arg_word;
  modport source (output valid, kind, data_byte, arg_word, input ready);
  modport sink (input valid, kind, data_byte, arg_word, output ready);
endinterface

interface psf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_last;
  logic       item_error;
  modport source (output valid, out_char, is_last, item_error, input ready);
  modport sink (input valid, out_char, is_last, item_error, output ready);
endinterface

@@ hw/rtl/psf_front.sv @@
// front end: parses the tagged stream and issues output commands
module psf_front #(
  parameter int MAX_WIDTH = psf_pkg::MAX_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  psf_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output psf_pkg::cmd_t  q_cmd
);

  psf_pkg::mode_t  mode_r, mode_nxt;
  psf_pkg::ctype_t ctype_r, ctype_nxt;
  logic [5:0] width_r, width_nxt;
  logic       zf_r, zf_nxt;
  logic [5:0] len_r, len_nxt;
  logic       push;
  logic       acc;
  logic [9:0] wsum;
  logic [7:0] b;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;
  assign q_push = acc && push;
  assign b = in_ch.data_byte;

  // width accumulation, saturating
  assign wsum = ({4'b0, width_r} << 3) + ({4'b0, width_r} << 1) + {6'b0, b[3:0]};

  // parse state update and command selection
  always_comb begin
    mode_nxt = mode_r;
    ctype_nxt = ctype_r;
    width_nxt = width_r;
    zf_nxt = zf_r;
    len_nxt = len_r;
    push = 1'b0;
    q_cmd = '0;
    q_cmd.op = psf_pkg::OP_BAD;
    q_cmd.chr = b;
    q_cmd.word = in_ch.arg_word;
    q_cmd.ctype = ctype_r;
    q_cmd.width = width_r;
    q_cmd.zf = zf_r;
    if (in_ch.kind == psf_pkg::KIND_FMT && mode_r == psf_pkg::MODE_TEXT) begin
      if (b == 8'h25) begin
        width_nxt = '0;
        zf_nxt = 1'b0;
        mode_nxt = psf_pkg::MODE_SPEC;
      end else if (b != 8'h00) begin
        push = 1'b1;
        q_cmd.op = psf_pkg::OP_CHAR;
      end
    end else if (in_ch.kind == psf_pkg::KIND_FMT && mode_r == psf_pkg::MODE_SPEC) begin
      if (b inside {[8'h30:8'h39]}) begin
        if (b == 8'h30 && width_r == 6'd0) zf_nxt = 1'b1;
        width_nxt = (wsum > 10'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : wsum[5:0];
      end else begin
        case (b)
          8'h63: begin
            ctype_nxt = psf_pkg::CT_CHAR;
            mode_nxt = psf_pkg::MODE_ARG;
          end
          8'h64, 8'h69: begin
            ctype_nxt = psf_pkg::CT_SDEC;
            mode_nxt = psf_pkg::MODE_ARG;
          end
          8'h75: begin
            ctype_nxt = psf_pkg::CT_UDEC;
            mode_nxt = psf_pkg::MODE_ARG;
          end
          8'h78, 8'h58, 8'h70: begin
            ctype_nxt = psf_pkg::CT_HEX;
            mode_nxt = psf_pkg::MODE_ARG;
          end
          8'h73: begin
            len_nxt = '0;
            mode_nxt = psf_pkg::MODE_STR;
          end
          8'h25: begin
            push = 1'b1;
            q_cmd.op = psf_pkg::OP_CHAR;
            mode_nxt = psf_pkg::MODE_TEXT;
          end
          default: begin
            push = 1'b1;
            q_cmd.op = psf_pkg::OP_ERRTXT;
            mode_nxt = psf_pkg::MODE_TEXT;
          end
        endcase
      end
    end else if (in_ch.kind == psf_pkg::KIND_ARG && mode_r == psf_pkg::MODE_ARG) begin
      push = 1'b1;
      if (ctype_r == psf_pkg::CT_CHAR) begin
        q_cmd.op = psf_pkg::OP_CHAR;
        q_cmd.chr = in_ch.arg_word[7:0];
      end else begin
        q_cmd.op = psf_pkg::OP_NUM;
      end
      mode_nxt = psf_pkg::MODE_TEXT;
    end else if (in_ch.kind == psf_pkg::KIND_STR && mode_r == psf_pkg::MODE_STR) begin
      if (b != 8'h00) begin
        push = 1'b1;
        q_cmd.op = psf_pkg::OP_CHAR;
        if (len_r != 6'd63) len_nxt = len_r + 6'd1;
      end else begin
        if (width_r > len_r) begin
          push = 1'b1;
          q_cmd.op = psf_pkg::OP_PAD;
          q_cmd.width = width_r - len_r;
          q_cmd.zf = 1'b0;
        end
        mode_nxt = psf_pkg::MODE_TEXT;
      end
    end else begin
      push = 1'b1;
      q_cmd.op = psf_pkg::OP_BAD;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= psf_pkg::MODE_TEXT;
      ctype_r <= psf_pkg::CT_CHAR;
      width_r <= '0;
      zf_r <= 1'b0;
      len_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      ctype_r <= ctype_nxt;
      width_r <= width_nxt;
      zf_r <= zf_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

@@ hw/rtl/psf_queue.sv @@
// two-entry command queue between front and back end
module psf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  psf_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  input  logic          pop,
  output psf_pkg::cmd_t head
);

  psf_pkg::cmd_t mem_r [psf_pkg::QDEPTH];
  logic [psf_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [psf_pkg::QPTR_W:0]   cnt_r;

  assign full = (cnt_r == (psf_pkg::QPTR_W+1)'(psf_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign head = mem_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

@@ hw/rtl/psf_back.sv @@
// back end: runs commands, converts numbers and drives output characters
`include "printf_stream_formatter_top_macros.svh"
module psf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  psf_pkg::cmd_t q_head,
  output logic          q_pop,
  psf_out_if.source     out_ch
);

  psf_pkg::bstate_t state_r, state_nxt;
  logic [31:0] v_r, v_nxt;
  logic        hex_r, hex_nxt;
  logic        neg_r, neg_nxt;
  logic        zf_r, zf_nxt;
  logic [5:0]  width_r, width_nxt;
  logic [3:0]  nd_r, nd_nxt;
  logic [3:0]  buf_r [psf_pkg::NDIG];
  logic        pre_r, pre_nxt;
  logic [5:0]  pad_r, pad_nxt;
  logic        post_r, post_nxt;
  logic [3:0]  dig_r, dig_nxt;
  logic [2:0]  eidx_r, eidx_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  ochar_r, ochar_nxt;
  logic        olast_r, olast_nxt;
  logic        oerr_r, oerr_nxt;
  logic        room, emit, dwr;
  logic [3:0]  dval;
  logic [63:0] prod;
  logic [31:0] q10, qv;
  logic [31:0] rem;
  logic [31:0] mag;
  logic [7:0]  padc;
  logic        wneg;
  logic [3:0]  didx;

  assign room = !ovalid_r || out_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.out_char = ochar_r;
  assign out_ch.is_last = olast_r;
  assign out_ch.item_error = oerr_r;

  // divide by ten through reciprocal multiply
  assign prod = v_r * 32'hcccccccd;
  assign q10 = {3'b0, prod[63:35]};
  assign rem = v_r - ((q10 << 3) + (q10 << 1));
  assign qv = hex_r ? {4'b0, v_r[31:4]} : q10;
  assign dval = hex_r ? v_r[3:0] : rem[3:0];
  assign wneg = (q_head.ctype == psf_pkg::CT_SDEC) && q_head.word[31];
  assign mag = wneg ? (32'd0 - q_head.word) : q_head.word;
  assign padc = {2'b0, width_r} - {4'b0, nd_r} - 8'd1 - {7'b0, neg_r};
  assign didx = dig_r - 4'd1;

  // command sequencer
  always_comb begin
    state_nxt = state_r;
    v_nxt = v_r;
    hex_nxt = hex_r;
    neg_nxt = neg_r;
    zf_nxt = zf_r;
    width_nxt = width_r;
    nd_nxt = nd_r;
    pre_nxt = pre_r;
    pad_nxt = pad_r;
    post_nxt = post_r;
    dig_nxt = dig_r;
    eidx_nxt = eidx_r;
    q_pop = 1'b0;
    emit = 1'b0;
    dwr = 1'b0;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    oerr_nxt = oerr_r;
    case (state_r)
      psf_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_head.op)
            psf_pkg::OP_CHAR: begin
              if (room) begin
                q_pop = 1'b1;
                emit = 1'b1;
                ochar_nxt = q_head.chr;
                olast_nxt = 1'b1;
                oerr_nxt = 1'b0;
              end
            end
            psf_pkg::OP_BAD: begin
              if (room) begin
                q_pop = 1'b1;
                emit = 1'b1;
                ochar_nxt = 8'h00;
                olast_nxt = 1'b1;
                oerr_nxt = 1'b1;
              end
            end
            psf_pkg::OP_ERRTXT: begin
              q_pop = 1'b1;
              eidx_nxt = '0;
              state_nxt = psf_pkg::B_ERR;
            end
            psf_pkg::OP_PAD: begin
              q_pop = 1'b1;
              zf_nxt = 1'b0;
              pre_nxt = 1'b0;
              post_nxt = 1'b0;
              dig_nxt = '0;
              pad_nxt = q_head.width;
              state_nxt = psf_pkg::B_OUT;
            end
            default: begin
              q_pop = 1'b1;
              v_nxt = mag;
              neg_nxt = wneg;
              hex_nxt = (q_head.ctype == psf_pkg::CT_HEX);
              zf_nxt = q_head.zf;
              width_nxt = q_head.width;
              nd_nxt = '0;
              state_nxt = psf_pkg::B_CONV;
            end
          endcase
        end
      end
      psf_pkg::B_CONV: begin
        dwr = 1'b1;
        v_nxt = qv;
        nd_nxt = nd_r + 4'd1;
        if (qv == 32'd0) begin
          pre_nxt = neg_r && zf_r;
          post_nxt = neg_r && !zf_r;
          pad_nxt = padc[7] ? 6'd0 : padc[5:0];
          dig_nxt = nd_r + 4'd1;
          state_nxt = psf_pkg::B_OUT;
        end
      end
      psf_pkg::B_OUT: begin
        if (room) begin
          emit = 1'b1;
          oerr_nxt = 1'b0;
          if (pre_r) begin
            ochar_nxt = 8'h2d;
            pre_nxt = 1'b0;
          end else if (pad_r != 6'd0) begin
            ochar_nxt = zf_r ? 8'h30 : 8'h20;
            pad_nxt = pad_r - 6'd1;
          end else if (post_r) begin
            ochar_nxt = 8'h2d;
            post_nxt = 1'b0;
          end else begin
            ochar_nxt = psf_pkg::hex_char(buf_r[didx]);
            dig_nxt = didx;
          end
          olast_nxt = !pre_nxt && (pad_nxt == 6'd0) && !post_nxt && (dig_nxt == 4'd0);
          if (olast_nxt) state_nxt = psf_pkg::B_IDLE;
        end
      end
      psf_pkg::B_ERR: begin
        if (room) begin
          emit = 1'b1;
          oerr_nxt = 1'b0;
          ochar_nxt = psf_pkg::err_char(eidx_r);
          olast_nxt = (eidx_r == 3'd4);
          eidx_nxt = eidx_r + 3'd1;
          if (olast_nxt) state_nxt = psf_pkg::B_IDLE;
        end
      end
      default: state_nxt = psf_pkg::B_IDLE;
    endcase
    ovalid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : ovalid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psf_pkg::B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    hex_r <= hex_nxt;
    neg_r <= neg_nxt;
    zf_r <= zf_nxt;
    width_r <= width_nxt;
    nd_r <= nd_nxt;
    pre_r <= pre_nxt;
    pad_r <= pad_nxt;
    post_r <= post_nxt;
    dig_r <= dig_nxt;
    eidx_r <= eidx_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
    oerr_r <= oerr_nxt;
    if (dwr) buf_r[nd_r] <= dval;
  end

  // digit buffer never overflows during conversion
  `PSF_ASSERT_IMPL(a_conv_bound, clk, rst_n, state_r == psf_pkg::B_CONV, nd_r <= 4'd9, "digit count overflow")
  // an output sequence always ends on a digit or a pad character
  `PSF_ASSERT_IMPL(a_out_nonempty, clk, rst_n, state_r == psf_pkg::B_OUT && !pre_r && pad_r == 6'd0 && !post_r, dig_r != 4'd0, "empty output sequence")
  // an error result is a single zero character marked last
  `PSF_ASSERT_IMPL(a_err_form, clk, rst_n, ovalid_r && oerr_r, ochar_r == 8'h00 && olast_r, "malformed error result")

endmodule

@@ hw/rtl/printf_stream_formatter_top.sv @@
// A literal or single character passes through a command queue entry, then the output character register.
// Numbers: digits come from the divide-by-ten / hex-shift unit (up to 10 digits),
// then one output character per cycle from the output register, unless out_ch stalls.
// Throughput: one character per cycle without back-pressure, set by the single output
// character register; the two-entry command queue lets the parser run ahead of output.
// Reset: synchronous active low; parser returns to literal text, queue and output empty.
module printf_stream_formatter_top #(
  parameter int MAX_WIDTH = psf_pkg::MAX_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  psf_in_if.sink     in_ch,
  psf_out_if.source  out_ch
);

  logic          q_full, q_push, q_valid, q_pop;
  psf_pkg::cmd_t q_cmd, q_head;

  psf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  psf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .head     (q_head)
  );

  psf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
